/* src/wav_pcm_header_check_top_macros.svh */
// assertion macros shared by the wav pcm header checker
`ifndef WAV_PCM_HEADER_CHECK_TOP_MACROS_SVH
`define WAV_PCM_HEADER_CHECK_TOP_MACROS_SVH

// clocked check, off while reset is held
`define WPH_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// clocked check that also holds through reset
`define WPH_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* src/wph_pkg.sv */
`default_nettype none

package wph_pkg;

    localparam logic [5:0] HDR_LEN = 6'd44;
    localparam logic [15:0] PCM_FORMAT = 16'd1;
    localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

    localparam logic [31:0] TAG_RIFF = "RIFF";
    localparam logic [31:0] TAG_WAVE = "WAVE";
    localparam logic [31:0] TAG_FMT = "fmt ";
    localparam logic [31:0] TAG_DATA = "data";

    localparam logic [23:0] KEY_MONO8 = 24'h000108;
    localparam logic [23:0] KEY_MONO16 = 24'h000110;
    localparam logic [23:0] KEY_STEREO8 = 24'h000208;
    localparam logic [23:0] KEY_STEREO16 = 24'h000210;

    typedef enum logic [2:0] {
        ST_OK = 3'd0,
        ST_SHORT = 3'd1,
        ST_BAD_TAG = 3'd2,
        ST_NOT_PCM = 3'd3,
        ST_SIZE = 3'd4,
        ST_LAYOUT = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        FMT_MONO8 = 2'd0,
        FMT_MONO16 = 2'd1,
        FMT_STEREO8 = 2'd2,
        FMT_STEREO16 = 2'd3
    } t_format;

    typedef struct packed {
        logic [31:0] payload_size;
        logic [31:0] sample_rate;
        t_format sample_format;
        t_status status;
    } t_verdict;

    typedef struct packed {
        logic chk;
        logic [7:0] value;
    } t_tag;

    // byte k of a tag word, first character in the top byte
    function automatic logic [7:0] tag_byte(input logic [31:0] tag, input logic [1:0] k);
        logic [4:0] sh;
        sh = 5'd24 - {k, 3'b000};
        return tag[sh +: 8];
    endfunction

    function automatic t_tag expected_tag(input logic [5:0] pos);
        t_tag t;
        t.chk = 1'b1;
        t.value = 8'd0;
        if (pos < 6'd4) begin
            t.value = tag_byte(TAG_RIFF, pos[1:0]);
        end else if (pos >= 6'd8 && pos < 6'd12) begin
            t.value = tag_byte(TAG_WAVE, pos[1:0]);
        end else if (pos >= 6'd12 && pos < 6'd16) begin
            t.value = tag_byte(TAG_FMT, pos[1:0]);
        end else if (pos >= 6'd36 && pos < 6'd40) begin
            t.value = tag_byte(TAG_DATA, pos[1:0]);
        end else begin
            t.chk = 1'b0;
        end
        return t;
    endfunction

endpackage

`default_nettype wire

/* src/wph_header_parse.sv */
`default_nettype none
`include "wav_pcm_header_check_top_macros.svh"

module wph_header_parse
    import wph_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_byte_en,
    input  wire logic [7:0] i_file_byte,
    input  wire logic     i_last_byte,
    output t_verdict      o_verdict
);

    logic [5:0]  r_pos, n_pos;
    logic        r_mis, n_mis;
    logic [15:0] r_fmt, n_fmt;
    logic [15:0] r_chan, n_chan;
    logic [31:0] r_rate, n_rate;
    logic [15:0] r_bits, n_bits;
    logic [31:0] r_size, n_size;
    logic [31:0] r_count, n_count;
    t_tag        tag;
    logic [23:0] key;

    always_comb begin
        n_pos = r_pos;
        n_mis = r_mis;
        n_fmt = r_fmt;
        n_chan = r_chan;
        n_rate = r_rate;
        n_bits = r_bits;
        n_size = r_size;
        n_count = r_count;
        tag = expected_tag(r_pos);
        if (i_byte_en) begin
            if (r_pos < HDR_LEN) begin
                if (tag.chk && (tag.value != i_file_byte)) begin
                    n_mis = 1'b1;
                end
                priority if (r_pos >= 6'd20 && r_pos < 6'd22) begin
                    n_fmt[{r_pos[0], 3'b000} +: 8] = i_file_byte;
                end else if (r_pos >= 6'd22 && r_pos < 6'd24) begin
                    n_chan[{r_pos[0], 3'b000} +: 8] = i_file_byte;
                end else if (r_pos >= 6'd24 && r_pos < 6'd28) begin
                    n_rate[{r_pos[1:0], 3'b000} +: 8] = i_file_byte;
                end else if (r_pos >= 6'd34 && r_pos < 6'd36) begin
                    n_bits[{r_pos[0], 3'b000} +: 8] = i_file_byte;
                end else if (r_pos >= 6'd40) begin
                    n_size[{r_pos[1:0], 3'b000} +: 8] = i_file_byte;
                end else begin
                    n_fmt = r_fmt;
                end
                n_pos = r_pos + 6'd1;
            end else if (r_count != COUNT_MAX) begin
                n_count = r_count + 32'd1;
            end
        end
    end

    // verdict on the state including the current byte
    always_comb begin
        key = {n_chan, 8'h00} | {8'h00, n_bits};
        o_verdict.sample_rate = n_rate;
        o_verdict.payload_size = n_size;
        o_verdict.sample_format = FMT_MONO8;
        o_verdict.status = ST_OK;
        priority if (n_pos < HDR_LEN) begin
            o_verdict.status = ST_SHORT;
        end else if (n_mis) begin
            o_verdict.status = ST_BAD_TAG;
        end else if (n_fmt != PCM_FORMAT) begin
            o_verdict.status = ST_NOT_PCM;
        end else if (n_size > n_count) begin
            o_verdict.status = ST_SIZE;
        end else begin
            unique case (key)
                KEY_MONO8: begin
                    o_verdict.sample_format = FMT_MONO8;
                end
                KEY_MONO16: begin
                    o_verdict.sample_format = FMT_MONO16;
                end
                KEY_STEREO8: begin
                    o_verdict.sample_format = FMT_STEREO8;
                end
                KEY_STEREO16: begin
                    o_verdict.sample_format = FMT_STEREO16;
                end
                default: begin
                    o_verdict.status = ST_LAYOUT;
                end
            endcase
        end
    end

    // a file ends on its last byte, the next byte opens a new one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_byte_en && i_last_byte)) begin
            r_pos <= '0;
            r_mis <= 1'b0;
            r_fmt <= '0;
            r_chan <= '0;
            r_rate <= '0;
            r_bits <= '0;
            r_size <= '0;
            r_count <= '0;
        end else begin
            r_pos <= n_pos;
            r_mis <= n_mis;
            r_fmt <= n_fmt;
            r_chan <= n_chan;
            r_rate <= n_rate;
            r_bits <= n_bits;
            r_size <= n_size;
            r_count <= n_count;
        end
    end

    `WPH_ASSERT(a_pos_cleared, (i_byte_en && i_last_byte) |=> (r_pos == '0 && r_count == '0), "state not cleared after last byte")
    `WPH_ASSERT_ALWAYS(a_pos_range, !i_rst_n || (r_pos <= HDR_LEN), "header position beyond header length")
    `WPH_ASSERT(a_count_idle, (r_pos < HDR_LEN) |-> (r_count == '0), "payload counted inside header")

endmodule

`default_nettype wire

/* src/wav_pcm_header_check_top.sv */
// wav pcm header checker
// input channel s_axis: one file byte per transaction, tlast on the final byte
// of a file; the byte after a tlast opens the next file.
// output channel m_axis: one verdict transaction per file, sent for the byte
// that carried tlast; bytes without tlast give no output.
// output register: the verdict is valid in the cycle after its last byte is accepted.
// throughput: one byte per cycle; the header fields are gathered byte by byte
// and the verdict is a single compare and select into the output register.
// when m_axis stalls with a verdict held, s_axis tready drops until it is
// taken; a verdict taken in the same cycle frees the slot at once.
// reset: synchronous, active low; clears the header position, tag flag,
// collected fields, payload count and the output valid.
// status codes: 0 ok, 1 too short, 2 bad tag, 3 not pcm, 4 size exceeds file,
// 5 unsupported layout; sample format is 0 whenever status is not ok.
// payload bytes after the 44 byte header are counted, saturating at the
// 32 bit maximum.
`default_nettype none
`include "wav_pcm_header_check_top_macros.svh"

module wav_pcm_header_check_top
    import wph_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // file_byte
    input  wire logic        i_s_axis_tlast,   // last_byte
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // status[2:0], sample_format[4:3], sample_rate[36:5], payload_size[68:37], zero pad
    output logic [71:0]      o_m_axis_tdata
);

    logic     in_acc;
    logic     r_out_valid;
    t_verdict r_out;
    t_verdict verdict;

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign in_acc = i_s_axis_tvalid && o_s_axis_tready;

    wph_header_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_byte_en   (in_acc),
        .i_file_byte (i_s_axis_tdata),
        .i_last_byte (i_s_axis_tlast),
        .o_verdict   (verdict)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc && i_s_axis_tlast) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && i_s_axis_tlast) begin
            r_out <= verdict;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata = {3'b000, r_out.payload_size, r_out.sample_rate,
                             r_out.sample_format, r_out.status};

    `WPH_ASSERT(a_last_gives_out, (in_acc && i_s_axis_tlast) |=> o_m_axis_tvalid, "no verdict after last byte")
    `WPH_ASSERT(a_no_stray_out, (!(in_acc && i_s_axis_tlast) && (!r_out_valid || i_m_axis_tready)) |=> !o_m_axis_tvalid, "verdict without last byte")
    `WPH_ASSERT(a_fmt_zero, (o_m_axis_tvalid && r_out.status != ST_OK) |-> (r_out.sample_format == FMT_MONO8), "format set on failed check")
    `WPH_ASSERT(a_no_overwrite, (r_out_valid && !i_m_axis_tready) |-> !in_acc, "byte taken while verdict stalled")

endmodule

`default_nettype wire

/* bench/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import wph_pkg::*;

    localparam int IDLE_LIMIT = 2000;
    localparam int RANDOM_BYTES = 540;
    localparam int RANDOM_FILES = 10;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_s_axis_tvalid = 1'b0;
    logic o_s_axis_tready;
    logic [7:0] i_s_axis_tdata = 8'h00;   // file_byte
    logic i_s_axis_tlast = 1'b0;          // last_byte
    logic o_m_axis_tvalid;
    logic i_m_axis_tready = 1'b0;
    // status[2:0], sample_format[4:3], sample_rate[36:5], payload_size[68:37], zero pad
    logic [71:0] o_m_axis_tdata;

    wav_pcm_header_check_top i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // header tracker state
    int hdr_pos = 0;
    logic tag_bad = 1'b0;
    logic [15:0] fmt_code = '0;
    logic [15:0] chan_count = '0;
    logic [31:0] rate_val = '0;
    logic [15:0] bit_depth = '0;
    logic [31:0] chunk_len = '0;
    logic [31:0] body_count = '0;

    t_verdict verdict_q[$];
    logic [7:0] file_q[$];

    int errors = 0;
    int files_sent = 0;
    int bytes_sent = 0;
    int verdicts_seen = 0;
    int status_seen[6];
    int burst_left = 0;
    int hold_left = 0;
    int idle_cycles = 0;

    // expected verdict bookkeeping for one accepted byte
    task automatic track_byte(input logic [7:0] b, input logic is_last);
        logic [31:0] tag_word;
        logic tag_here;
        logic [23:0] key;
        t_verdict v;
        tag_here = 1'b1;
        tag_word = '0;
        if (hdr_pos < HDR_LEN) begin
            if (hdr_pos < 4) tag_word = TAG_RIFF;
            else if (hdr_pos >= 8 && hdr_pos < 12) tag_word = TAG_WAVE;
            else if (hdr_pos >= 12 && hdr_pos < 16) tag_word = TAG_FMT;
            else if (hdr_pos >= 36 && hdr_pos < 40) tag_word = TAG_DATA;
            else tag_here = 1'b0;
            if (tag_here && b != tag_word[8 * (3 - hdr_pos % 4) +: 8]) tag_bad = 1'b1;
            if (hdr_pos >= 20 && hdr_pos < 22) fmt_code[8 * (hdr_pos - 20) +: 8] = b;
            else if (hdr_pos >= 22 && hdr_pos < 24) chan_count[8 * (hdr_pos - 22) +: 8] = b;
            else if (hdr_pos >= 24 && hdr_pos < 28) rate_val[8 * (hdr_pos - 24) +: 8] = b;
            else if (hdr_pos >= 34 && hdr_pos < 36) bit_depth[8 * (hdr_pos - 34) +: 8] = b;
            else if (hdr_pos >= 40 && hdr_pos < 44) chunk_len[8 * (hdr_pos - 40) +: 8] = b;
            hdr_pos++;
        end else if (body_count != COUNT_MAX) begin
            body_count++;
        end
        if (is_last) begin
            v = '0;
            v.sample_rate = rate_val;
            v.payload_size = chunk_len;
            if (hdr_pos < HDR_LEN) begin
                v.status = ST_SHORT;
            end else if (tag_bad) begin
                v.status = ST_BAD_TAG;
            end else if (fmt_code != PCM_FORMAT) begin
                v.status = ST_NOT_PCM;
            end else if (chunk_len > body_count) begin
                v.status = ST_SIZE;
            end else begin
                key = {chan_count, 8'h00} | {8'h00, bit_depth};
                case (key)
                    KEY_MONO8: v.sample_format = FMT_MONO8;
                    KEY_MONO16: v.sample_format = FMT_MONO16;
                    KEY_STEREO8: v.sample_format = FMT_STEREO8;
                    KEY_STEREO16: v.sample_format = FMT_STEREO16;
                    default: v.status = ST_LAYOUT;
                endcase
            end
            verdict_q.push_back(v);
            hdr_pos = 0;
            tag_bad = 1'b0;
            fmt_code = '0;
            chan_count = '0;
            rate_val = '0;
            bit_depth = '0;
            chunk_len = '0;
            body_count = '0;
        end
    endtask

    // one byte over s_axis, with bursts and gaps
    task automatic send_byte(input logic [7:0] b, input logic is_last);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 64);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            i_s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tdata = b;
        i_s_axis_tlast = is_last;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        track_byte(b, is_last);
        bytes_sent++;
        burst_left--;
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tlast = 1'b0;
    endtask

    task automatic send_file();
        for (int i = 0; i < file_q.size(); i++) send_byte(file_q[i], i == file_q.size() - 1);
        file_q.delete();
        files_sent++;
    endtask

    task automatic push_le(input logic [31:0] v, input int n);
        for (int k = 0; k < n; k++) file_q.push_back(v[8 * k +: 8]);
    endtask

    task automatic push_tag(input logic [31:0] t);
        for (int k = 3; k >= 0; k--) file_q.push_back(t[8 * k +: 8]);
    endtask

    task automatic build_file(input logic [15:0] fc, input logic [15:0] ch,
                              input logic [31:0] rate, input logic [15:0] depth,
                              input logic [31:0] dsize, input int plen);
        push_tag(TAG_RIFF);
        push_le($urandom, 4);
        push_tag(TAG_WAVE);
        push_tag(TAG_FMT);
        push_le(32'd16, 4);
        push_le(32'(fc), 2);
        push_le(32'(ch), 2);
        push_le(rate, 4);
        push_le($urandom, 4);
        push_le($urandom, 2);
        push_le(32'(depth), 2);
        push_tag(TAG_DATA);
        push_le(dsize, 4);
        for (int k = 0; k < plen; k++) file_q.push_back(8'($urandom));
    endtask

    task automatic truncate_file(input int n);
        while (file_q.size() > n) file_q.delete(file_q.size() - 1);
    endtask

    task automatic wait_drain();
        while (verdict_q.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // receiver: long hold-off when asked, otherwise a changing stall pattern
    int rx_cycle = 0;
    int rx_mode = 0;
    always @(negedge i_clk) begin
        rx_cycle++;
        if (rx_cycle % 64 == 0) rx_mode = $urandom_range(0, 3);
        if (hold_left > 0) begin
            hold_left--;
            i_m_axis_tready = 1'b0;
        end else begin
            case (rx_mode)
                0: i_m_axis_tready = 1'b1;
                1: i_m_axis_tready = $urandom_range(0, 3) != 0;
                2: i_m_axis_tready = $urandom_range(0, 9) < 3;
                default: i_m_axis_tready = (rx_cycle % 5) == 0;
            endcase
        end
    end

    t_verdict got_v, want_v;
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got_v = t_verdict'(o_m_axis_tdata[68:0]);
            if (verdict_q.size() == 0) begin
                $display("%0t: verdict with nothing expected, actual %h", $time, o_m_axis_tdata);
                errors++;
            end else begin
                want_v = verdict_q.pop_front();
                verdicts_seen++;
                status_seen[want_v.status]++;
                if (got_v.status !== want_v.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want_v.status, got_v.status);
                    errors++;
                end
                if (got_v.sample_format !== want_v.sample_format) begin
                    $display("%0t: sample_format expected %0d actual %0d",
                             $time, want_v.sample_format, got_v.sample_format);
                    errors++;
                end
                if (got_v.sample_rate !== want_v.sample_rate) begin
                    $display("%0t: sample_rate expected %h actual %h",
                             $time, want_v.sample_rate, got_v.sample_rate);
                    errors++;
                end
                if (got_v.payload_size !== want_v.payload_size) begin
                    $display("%0t: payload_size expected %h actual %h",
                             $time, want_v.payload_size, got_v.payload_size);
                    errors++;
                end
                if (o_m_axis_tdata[71:69] !== 3'b000) begin
                    $display("%0t: tdata pad expected 0 actual %b",
                             $time, o_m_axis_tdata[71:69]);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
            $display("FAIL");
            $finish;
        end
    end

    task automatic test_layouts();
        build_file(16'd1, 16'd1, 32'd8000, 16'd8, 32'd3, 3);
        send_file();
        build_file(16'd1, 16'd1, 32'h0000_0000, 16'd16, 32'd4, 6);
        send_file();
        build_file(16'd1, 16'd2, 32'hFFFF_FFFF, 16'd8, 32'd0, 0);
        send_file();
        build_file(16'd1, 16'd2, 32'd44100, 16'd16, 32'd8, 8);
        send_file();
        // zero channels with the channel count hidden in the high bits byte
        build_file(16'd1, 16'd0, 32'd22050, 16'h0108, 32'd1, 1);
        send_file();
        build_file(16'd1, 16'd0, 32'd48000, 16'h0210, 32'd2, 5);
        send_file();
    endtask

    task automatic test_status_codes();
        file_q.push_back(8'hFF);
        send_file();
        build_file(16'd1, 16'd1, 32'd8000, 16'd8, 32'd0, 0);
        truncate_file(43);
        send_file();
        build_file(16'd1, 16'd2, 32'd16000, 16'd16, 32'h0, 0);
        file_q[0] = 8'h00;
        send_file();
        build_file(16'd1, 16'd2, 32'd16000, 16'd16, 32'h0, 2);
        file_q[39] = file_q[39] ^ 8'h80;
        send_file();
        build_file(16'h0101, 16'd1, 32'd8000, 16'd8, 32'd0, 0);
        send_file();
        build_file(16'd1, 16'd1, 32'd8000, 16'd8, 32'd5, 4);
        send_file();
        build_file(16'd1, 16'd2, 32'd8000, 16'd16, 32'hFFFF_FFFF, 3);
        send_file();
        build_file(16'd1, 16'd3, 32'd8000, 16'd16, 32'd0, 0);
        send_file();
        build_file(16'd1, 16'd2, 32'd96000, 16'd24, 32'd0, 1);
        send_file();
        build_file(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 32'd0, 1);
        send_file();
    endtask

    task automatic test_priority();
        // too short beats a bad tag
        file_q.push_back("R");
        file_q.push_back("I");
        file_q.push_back("X");
        send_file();
        // bad tag beats not pcm
        build_file(16'd3, 16'd1, 32'd8000, 16'd8, 32'd0, 0);
        file_q[14] = 8'h00;
        send_file();
        // not pcm beats size exceeds file
        build_file(16'd0, 16'd1, 32'd8000, 16'd8, 32'd9, 0);
        send_file();
        // size exceeds file beats unsupported layout
        build_file(16'd1, 16'd7, 32'd8000, 16'd12, 32'd9, 8);
        send_file();
    endtask

    task automatic test_backpressure();
        hold_left = 300;
        for (int f = 0; f < 12; f++) begin
            for (int k = $urandom_range(0, 2); k > 0; k--) file_q.push_back(8'($urandom));
            file_q.push_back(8'($urandom));
            send_file();
        end
        wait_drain();
    endtask

    task automatic random_file();
        int kind;
        int plen;
        logic [15:0] fc, ch, depth;
        logic [31:0] rate, dsize;
        kind = $urandom_range(0, 99);
        fc = ($urandom_range(0, 9) != 0) ? PCM_FORMAT : 16'($urandom);
        ch = ($urandom_range(0, 6) != 0) ? 16'($urandom_range(1, 2)) : 16'($urandom);
        depth = ($urandom_range(0, 6) != 0) ? (($urandom_range(0, 1) != 0) ? 16'd8 : 16'd16)
                                            : 16'($urandom);
        case ($urandom_range(0, 4))
            0: rate = 32'd44100;
            1: rate = 32'h0000_0000;
            2: rate = 32'hFFFF_FFFF;
            default: rate = $urandom;
        endcase
        plen = ($urandom_range(0, 29) == 0) ? $urandom_range(100, 400) : $urandom_range(0, 12);
        case ($urandom_range(0, 9))
            0, 1: dsize = plen + 1;
            2: dsize = $urandom;
            3, 4: dsize = $urandom_range(0, plen);
            default: dsize = plen;
        endcase
        if (kind < 70) begin
            build_file(fc, ch, rate, depth, dsize, plen);
            if ($urandom_range(0, 9) == 0)
                file_q[$urandom_range(0, 43)] = 8'($urandom);
        end else if (kind < 85) begin
            build_file(fc, ch, rate, depth, dsize, 0);
            truncate_file($urandom_range(1, 44));
        end else begin
            for (int k = $urandom_range(1, 60); k > 0; k--) file_q.push_back(8'($urandom));
        end
        send_file();
    endtask

    task automatic test_random();
        int start_bytes, start_files;
        start_bytes = bytes_sent;
        start_files = files_sent;
        while (bytes_sent - start_bytes < RANDOM_BYTES || files_sent - start_files < RANDOM_FILES) begin
            random_file();
            if ($urandom_range(0, 49) == 0) wait_drain();
        end
    endtask

    initial begin
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_layouts();
        test_status_codes();
        test_priority();
        test_backpressure();
        test_random();
        wait_drain();
        repeat (8) @(posedge i_clk);
        if (verdict_q.size() != 0) begin
            $display("%0t: %0d verdicts expected but never sent", $time, verdict_q.size());
            errors++;
        end
        $display("files %0d, bytes %0d, verdicts %0d", files_sent, bytes_sent, verdicts_seen);
        $display("by status ok %0d short %0d tag %0d pcm %0d size %0d layout %0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4], status_seen[5]);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+src
src/wph_pkg.sv
src/wph_header_parse.sv
src/wav_pcm_header_check_top.sv
bench/testbench.sv
